### rtl/core/rtc_pkg.sv
// shared types, constants and bcd helper functions for the rtc calendar unit
// no dependencies; used by the top level and the testbench
package rtc_pkg;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_SET_TIME = 2'd1,
    MODE_SET_DATE = 2'd2
  } mode_t;

  localparam logic [5:0] HOUR_LAST  = 6'h23;
  localparam logic [6:0] MINUTE_LAST = 7'h59;
  localparam logic [6:0] SECOND_LAST = 7'h59;
  localparam logic [7:0] YEAR_LAST  = 8'h99;
  localparam logic [4:0] MONTH_LAST = 5'h12;

  localparam logic [7:0] YEAR_RESET  = 8'h10;
  localparam logic [4:0] MONTH_RESET = 5'h05;
  localparam logic [5:0] DAY_RESET   = 6'h05;

  // both nibbles are decimal digits
  function automatic logic bcd_ok(input logic [7:0] v);
    return (v[7:4] <= 4'd9) && (v[3:0] <= 4'd9);
  endfunction

  // next bcd value, no wrap at the top
  function automatic logic [7:0] bcd_inc(input logic [7:0] v);
    logic [7:0] r;
    if (v[3:0] >= 4'd9) begin
      r = {v[7:4] + 4'd1, 4'd0};
    end else begin
      r = {v[7:4], v[3:0] + 4'd1};
    end
    return r;
  endfunction

  // year divisible by four, year in bcd
  function automatic logic leap_bcd(input logic [7:0] y);
    logic lp;
    if (y[4]) begin
      lp = (y[3:0] == 4'd2) || (y[3:0] == 4'd6);
    end else begin
      lp = (y[3:0] == 4'd0) || (y[3:0] == 4'd4) || (y[3:0] == 4'd8);
    end
    return lp;
  endfunction

  // last day of a bcd month, as bcd
  function automatic logic [5:0] month_len_bcd(input logic [4:0] m, input logic leap);
    logic [5:0] len;
    case (m) inside
      5'h04, 5'h06, 5'h09, 5'h11: len = 6'h30;
      5'h02:                      len = leap ? 6'h29 : 6'h28;
      default:                    len = 6'h31;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/rtc_if.sv
// valid/ready channel interfaces for the rtc calendar unit
// no dependencies; one beat carries one command or one result
interface rtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] first_bcd;
  logic [7:0] second_bcd;
  logic [7:0] third_bcd;

  modport source (output valid, output mode, output first_bcd, output second_bcd,
                  output third_bcd, input ready);
  modport sink   (input valid, input mode, input first_bcd, input second_bcd,
                  input third_bcd, output ready);
endinterface

interface rtc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] hours_bcd;
  logic [6:0] minutes_bcd;
  logic [6:0] seconds_bcd;
  logic [7:0] year_bcd;
  logic [4:0] month_bcd;
  logic [5:0] day_bcd;
  logic       new_day;
  logic       rejected;

  modport source (output valid, output hours_bcd, output minutes_bcd, output seconds_bcd,
                  output year_bcd, output month_bcd, output day_bcd, output new_day,
                  output rejected, input ready);
  modport sink   (input valid, input hours_bcd, input minutes_bcd, input seconds_bcd,
                  input year_bcd, input month_bcd, input day_bcd, input new_day,
                  input rejected, output ready);
endinterface

### rtl/core/rtc_time_and_calendar_unit.sv
// rtc time and calendar unit: bcd clock 00:00:00..23:59:59, dates 2000..2099
// stages: the input stage registers a command, the result stage registers its reading; a full result stage holds it
// throughput: one command per cycle while the result channel is not stalled; the state update is one bcd carry chain
// reset (sync, active low): time 00:00:00, date 2010-05-05, both stages empty
// depends on rtc_pkg and the channel interfaces in rtc_if.sv
module rtc_time_and_calendar_unit (
  input  logic      clk,
  input  logic      rst_n,
  rtc_in_if.sink    in_ch,
  rtc_out_if.source out_ch
);
  import rtc_pkg::*;

  // input stage
  logic       in_vld_r;
  logic [1:0] mode_r;
  logic [7:0] a_r, b_r, c_r;

  // time and date kept directly in packed bcd
  logic [5:0] hour_r,  hour_nxt;
  logic [6:0] min_r,   min_nxt;
  logic [6:0] sec_r,   sec_nxt;
  logic [7:0] year_r,  year_nxt;
  logic [4:0] month_r, month_nxt;
  logic [5:0] day_r,   day_nxt;
  logic       new_day_nxt, rej_nxt;

  // result stage
  logic       out_vld_r;
  logic [5:0] out_hour_r;
  logic [6:0] out_min_r, out_sec_r;
  logic [7:0] out_year_r;
  logic [4:0] out_month_r;
  logic [5:0] out_day_r;
  logic       out_new_day_r, out_rej_r;

  logic advance, fire;
  logic time_ok, date_ok;
  logic [5:0] cur_len, set_len;

  // result stage can take a beat when empty or draining this cycle
  assign advance     = !out_vld_r || out_ch.ready;
  assign fire        = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  // range checks for the set commands
  assign time_ok = bcd_ok(a_r) && bcd_ok(b_r) && bcd_ok(c_r) &&
                   (a_r <= {2'b00, HOUR_LAST}) && (b_r <= {1'b0, MINUTE_LAST}) &&
                   (c_r <= {1'b0, SECOND_LAST});
  assign set_len = month_len_bcd(b_r[4:0], leap_bcd(a_r));
  assign date_ok = bcd_ok(a_r) && bcd_ok(b_r) && bcd_ok(c_r) &&
                   (b_r >= 8'h01) && (b_r <= {3'b000, MONTH_LAST}) &&
                   (c_r >= 8'h01) && (c_r <= {2'b00, set_len});

  assign cur_len = month_len_bcd(month_r, leap_bcd(year_r));

  // next state for the command in the input stage
  always_comb begin
    hour_nxt    = hour_r;
    min_nxt     = min_r;
    sec_nxt     = sec_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    new_day_nxt = 1'b0;
    rej_nxt     = 1'b0;
    case (mode_r)
      MODE_TICK: begin
        if (sec_r >= SECOND_LAST) begin
          sec_nxt = '0;
          if (min_r >= MINUTE_LAST) begin
            min_nxt = '0;
            if (hour_r >= HOUR_LAST) begin
              // midnight: roll the date
              hour_nxt    = '0;
              new_day_nxt = 1'b1;
              if (day_r >= cur_len) begin
                day_nxt = 6'h01;
                if (month_r >= MONTH_LAST) begin
                  month_nxt = 5'h01;
                  year_nxt  = (year_r >= YEAR_LAST) ? 8'h00 : bcd_inc(year_r);
                end else begin
                  month_nxt = 5'(bcd_inc({3'b000, month_r}));
                end
              end else begin
                day_nxt = 6'(bcd_inc({2'b00, day_r}));
              end
            end else begin
              hour_nxt = 6'(bcd_inc({2'b00, hour_r}));
            end
          end else begin
            min_nxt = 7'(bcd_inc({1'b0, min_r}));
          end
        end else begin
          sec_nxt = 7'(bcd_inc({1'b0, sec_r}));
        end
      end
      MODE_SET_TIME: begin
        if (time_ok) begin
          hour_nxt = a_r[5:0];
          min_nxt  = b_r[6:0];
          sec_nxt  = c_r[6:0];
        end else begin
          rej_nxt = 1'b1;
        end
      end
      MODE_SET_DATE: begin
        if (date_ok) begin
          year_nxt  = a_r;
          month_nxt = b_r[4:0];
          day_nxt   = c_r[5:0];
        end else begin
          rej_nxt = 1'b1;
        end
      end
      default: begin
        // unused code: state held, no flags
      end
    endcase
  end

  // control and clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      hour_r    <= '0;
      min_r     <= '0;
      sec_r     <= '0;
      year_r    <= YEAR_RESET;
      month_r   <= MONTH_RESET;
      day_r     <= DAY_RESET;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (fire) begin
        hour_r  <= hour_nxt;
        min_r   <= min_nxt;
        sec_r   <= sec_nxt;
        year_r  <= year_nxt;
        month_r <= month_nxt;
        day_r   <= day_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      mode_r <= in_ch.mode;
      a_r    <= in_ch.first_bcd;
      b_r    <= in_ch.second_bcd;
      c_r    <= in_ch.third_bcd;
    end
    if (fire) begin
      out_hour_r    <= hour_nxt;
      out_min_r     <= min_nxt;
      out_sec_r     <= sec_nxt;
      out_year_r    <= year_nxt;
      out_month_r   <= month_nxt;
      out_day_r     <= day_nxt;
      out_new_day_r <= new_day_nxt;
      out_rej_r     <= rej_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.hours_bcd   = out_hour_r;
  assign out_ch.minutes_bcd = out_min_r;
  assign out_ch.seconds_bcd = out_sec_r;
  assign out_ch.year_bcd    = out_year_r;
  assign out_ch.month_bcd   = out_month_r;
  assign out_ch.day_bcd     = out_day_r;
  assign out_ch.new_day     = out_new_day_r;
  assign out_ch.rejected    = out_rej_r;

  // time counters always hold legal bcd
  a_time_legal: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_ok({2'b00, hour_r}) && bcd_ok({1'b0, min_r}) && bcd_ok({1'b0, sec_r}) &&
    (hour_r <= HOUR_LAST) && (min_r <= MINUTE_LAST) && (sec_r <= SECOND_LAST))
    else $error("time counters out of range");

  // date always a real calendar day
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_ok(year_r) && (month_r >= 5'h01) && (month_r <= MONTH_LAST) &&
    (day_r >= 6'h01) && (day_r <= cur_len))
    else $error("date counters out of range");

  // a date roll lands on midnight and is never a refused set
  a_new_day_midnight: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_new_day_r |->
      !out_rej_r && (out_hour_r == '0) && (out_min_r == '0) && (out_sec_r == '0))
    else $error("new_day without midnight");

  // state only moves when a command leaves the input stage
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(sec_r) && $stable(day_r))
    else $error("state changed without a command");

  // a stalled command stays in the input stage
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r)
    else $error("input stage dropped a command");

endmodule

### tb/tb_rtc_time_and_calendar_unit.sv
// self-checking testbench for the rtc time and calendar unit: predicted bcd readings vs dut
// depends on rtc_pkg, the channel interfaces in rtc_if.sv and rtc_time_and_calendar_unit
module tb_rtc_time_and_calendar_unit;
  import rtc_pkg::*;

  // the fourth mode code is not in the package enum; the dut must ignore it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_CMDS = 1700;
  localparam int HOLD_AFTER  = 300;   // accepted commands before the long receiver hold-off
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;   // quiet time after the last reading, covers the latency

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] first_bcd;
    logic [7:0] second_bcd;
    logic [7:0] third_bcd;
  } rtc_cmd_t;

  typedef struct packed {
    logic [5:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic       new_day;
    logic       rejected;
  } rtc_reading_t;

  logic clk;
  logic rst_n;

  rtc_in_if  in_ch ();
  rtc_out_if out_ch ();

  rtc_time_and_calendar_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // commands waiting to be driven, readings waiting to come out
  rtc_cmd_t     pending_cmds[$];
  rtc_reading_t predicted_readings[$];

  // predicted clock and calendar, kept in binary, unlike the packed bcd counters of the block
  logic [4:0] hour_q;
  logic [5:0] min_q;
  logic [5:0] sec_q;
  logic [6:0] year_q;
  logic [3:0] month_q;
  logic [4:0] day_q;

  // handshakes seen at the last rising edge, used by the falling-edge drivers
  logic in_took;
  logic out_took;

  int total_cmds;
  int accepted_cmds;
  int readings_seen;
  int mismatches;
  int tick_cmds, set_time_cmds, set_date_cmds, unused_cmds;
  int rollovers, refusals;

  // ---------------------------------------------------------------------------
  // calendar arithmetic
  // ---------------------------------------------------------------------------

  // every year divisible by four is a leap year here, 2000 included
  function automatic int month_days(int month, int year);
    case (month)
      4, 6, 9, 11: return 30;
      2:           return (year % 4 == 0) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // -1 when either nibble is not a decimal digit
  function automatic int bcd_value(logic [7:0] v);
    if (v[7:4] > 4'd9 || v[3:0] > 4'd9) begin
      return -1;
    end
    return int'(v[7:4]) * 10 + int'(v[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(int n);
    logic [7:0] r;
    r[7:4] = 4'(n / 10);
    r[3:0] = 4'(n % 10);
    return r;
  endfunction

  // applies one command to the predicted state and returns the reading it causes
  function automatic rtc_reading_t rtc_apply(rtc_cmd_t cmd);
    rtc_reading_t rd;
    logic [7:0]   enc;
    int           a, b, c;
    rd.new_day  = 1'b0;
    rd.rejected = 1'b0;
    a = bcd_value(cmd.first_bcd);
    b = bcd_value(cmd.second_bcd);
    c = bcd_value(cmd.third_bcd);
    case (cmd.mode)
      MODE_TICK: begin
        // seconds -> minutes -> hours -> date carry chain
        if (sec_q >= 6'd59) begin
          sec_q = 6'd0;
          if (min_q >= 6'd59) begin
            min_q = 6'd0;
            if (hour_q >= 5'd23) begin
              hour_q     = 5'd0;
              rd.new_day = 1'b1;
              if (int'(day_q) >= month_days(int'(month_q), int'(year_q))) begin
                day_q = 5'd1;
                if (month_q >= 4'd12) begin
                  month_q = 4'd1;
                  // end of 2099 wraps to 2000
                  year_q  = (year_q >= 7'd99) ? 7'd0 : year_q + 7'd1;
                end else begin
                  month_q = month_q + 4'd1;
                end
              end else begin
                day_q = day_q + 5'd1;
              end
            end else begin
              hour_q = hour_q + 5'd1;
            end
          end else begin
            min_q = min_q + 6'd1;
          end
        end else begin
          sec_q = sec_q + 6'd1;
        end
      end
      MODE_SET_TIME: begin
        if (a >= 0 && b >= 0 && c >= 0 && a <= 23 && b <= 59 && c <= 59) begin
          hour_q = a[4:0];
          min_q  = b[5:0];
          sec_q  = c[5:0];
        end else begin
          rd.rejected = 1'b1;
        end
      end
      MODE_SET_DATE: begin
        // the day limit uses the year being loaded, not the current one
        if (a >= 0 && b >= 1 && b <= 12 && c >= 1 && c <= month_days(b, a)) begin
          year_q  = a[6:0];
          month_q = b[3:0];
          day_q   = c[4:0];
        end else begin
          rd.rejected = 1'b1;
        end
      end
      default: begin
        // unused mode: state held, both flags low
      end
    endcase
    enc = to_bcd(int'(hour_q));
    rd.hours = enc[5:0];
    enc = to_bcd(int'(min_q));
    rd.minutes = enc[6:0];
    enc = to_bcd(int'(sec_q));
    rd.seconds = enc[6:0];
    enc = to_bcd(int'(year_q));
    rd.year = enc;
    enc = to_bcd(int'(month_q));
    rd.month = enc[4:0];
    enc = to_bcd(int'(day_q));
    rd.day = enc[5:0];
    return rd;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_cmd(logic [1:0] mode, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    rtc_cmd_t cmd;
    cmd.mode       = mode;
    cmd.first_bcd  = a;
    cmd.second_bcd = b;
    cmd.third_bcd  = c;
    pending_cmds.push_back(cmd);
  endtask

  // legal date, mostly at or just before the end of its month
  task automatic queue_good_date();
    int y, mo, len, d;
    y   = $urandom_range(0, 99);
    mo  = $urandom_range(1, 12);
    len = month_days(mo, y);
    case ($urandom_range(0, 4))
      0, 1:    d = len;
      2:       d = len - 1;
      default: d = $urandom_range(1, len);
    endcase
    queue_cmd(MODE_SET_DATE, to_bcd(y), to_bcd(mo), to_bcd(d));
  endtask

  // legal time; a late one sits close to midnight so a few ticks roll the date
  task automatic queue_good_time(bit late);
    int h, m, s;
    if (late) begin
      h = ($urandom_range(0, 4) != 0) ? 23 : $urandom_range(0, 23);
      m = ($urandom_range(0, 4) != 0) ? 59 : $urandom_range(0, 59);
      s = $urandom_range(40, 59);
    end else begin
      h = $urandom_range(0, 23);
      m = $urandom_range(0, 59);
      s = $urandom_range(0, 59);
    end
    queue_cmd(MODE_SET_TIME, to_bcd(h), to_bcd(m), to_bcd(s));
  endtask

  // tick fields are don't-care, so random bytes exercise every payload bit
  task automatic queue_ticks(int n);
    repeat (n) begin
      queue_cmd(MODE_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // rising edge: predict on every accepted command beat, check every result beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    rtc_cmd_t     cmd;
    rtc_reading_t want;
    rtc_reading_t got;
    if (!rst_n) begin
      // reset state: 00:00:00 on 2010-05-05
      hour_q   = 5'd0;
      min_q    = 6'd0;
      sec_q    = 6'd0;
      year_q   = 7'd10;
      month_q  = 4'd5;
      day_q    = 5'd5;
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_ch.valid && in_ch.ready;
      out_took <= out_ch.valid && out_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        cmd.mode       = in_ch.mode;
        cmd.first_bcd  = in_ch.first_bcd;
        cmd.second_bcd = in_ch.second_bcd;
        cmd.third_bcd  = in_ch.third_bcd;
        want = rtc_apply(cmd);
        predicted_readings.push_back(want);
        accepted_cmds++;
        case (cmd.mode)
          MODE_TICK:     tick_cmds++;
          MODE_SET_TIME: set_time_cmds++;
          MODE_SET_DATE: set_date_cmds++;
          default:       unused_cmds++;
        endcase
        if (want.new_day) rollovers++;
        if (want.rejected) refusals++;
      end
      // a command passes through the input and result stages first, so a beat never checks against itself
      if (out_ch.valid && out_ch.ready) begin
        got.hours    = out_ch.hours_bcd;
        got.minutes  = out_ch.minutes_bcd;
        got.seconds  = out_ch.seconds_bcd;
        got.year     = out_ch.year_bcd;
        got.month    = out_ch.month_bcd;
        got.day      = out_ch.day_bcd;
        got.new_day  = out_ch.new_day;
        got.rejected = out_ch.rejected;
        if (predicted_readings.size() == 0) begin
          $display("%0t: result beat with nothing expected, got 0x%0h", $time, got);
          mismatches++;
        end else begin
          want = predicted_readings.pop_front();
          check_field("hours_bcd",   8'(want.hours),    8'(got.hours));
          check_field("minutes_bcd", 8'(want.minutes),  8'(got.minutes));
          check_field("seconds_bcd", 8'(want.seconds),  8'(got.seconds));
          check_field("year_bcd",    want.year,         got.year);
          check_field("month_bcd",   8'(want.month),    8'(got.month));
          check_field("day_bcd",     8'(want.day),      8'(got.day));
          check_field("new_day",     8'(want.new_day),  8'(got.new_day));
          check_field("rejected",    8'(want.rejected), 8'(got.rejected));
          readings_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // falling edge: command driver, random gap before each beat
  // ---------------------------------------------------------------------------
  int send_gap;
  int send_calm;   // beats left in a back-to-back stretch

  always @(negedge clk) begin : cmd_driver
    rtc_cmd_t nxt;
    logic     v;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      v = in_ch.valid;
      if (in_took) begin
        v = 1'b0;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(20, 60);
          send_gap = $urandom_range(0, 9);
        end
      end
      // valid is computed once per step, so a back-to-back beat keeps it high
      if (!v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          in_ch.mode       <= nxt.mode;
          in_ch.first_bcd  <= nxt.first_bcd;
          in_ch.second_bcd <= nxt.second_bcd;
          in_ch.third_bcd  <= nxt.third_bcd;
          v = 1'b1;
        end
      end
      in_ch.valid <= v;
    end
  end

  // ---------------------------------------------------------------------------
  // falling edge: result receiver, random stall after each beat plus one long hold-off
  // ---------------------------------------------------------------------------
  int  recv_wait;
  int  recv_calm;
  int  hold_left;
  bit  hold_done;

  always @(negedge clk) begin : result_sink
    logic r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_took) begin
        if (recv_calm > 0) begin
          recv_calm--;
          recv_wait = 0;
        end else begin
          if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(20, 60);
          recv_wait = $urandom_range(0, 9);
        end
      end
      // long hold-off: the sender keeps offering until the dut backs up
      if (!hold_done && accepted_cmds >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        r = 1'b0;
      end else begin
        r = 1'b1;
      end
      out_ch.ready <= r;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int made;
    int pick;
    int n;
    int y, mo;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_TICK;
    in_ch.first_bcd   = 8'h00;
    in_ch.second_bcd  = 8'h00;
    in_ch.third_bcd   = 8'h00;
    out_ch.ready      = 1'b0;
    send_gap          = 0;
    send_calm         = 0;
    recv_wait         = 0;
    recv_calm         = 0;
    hold_left         = 0;
    hold_done         = 1'b0;
    accepted_cmds     = 0;
    readings_seen     = 0;
    mismatches        = 0;
    tick_cmds         = 0;
    set_time_cmds     = 0;
    set_date_cmds     = 0;
    unused_cmds       = 0;
    rollovers         = 0;
    refusals          = 0;

    // directed: first tick from reset, midnight rollover
    queue_cmd(MODE_TICK, 8'h00, 8'h00, 8'h00);
    queue_cmd(MODE_SET_TIME, 8'h23, 8'h59, 8'h59);
    queue_cmd(MODE_TICK, 8'hff, 8'hff, 8'hff);
    // last second of 2099 wraps to new year 2000
    queue_cmd(MODE_SET_DATE, 8'h99, 8'h12, 8'h31);
    queue_cmd(MODE_SET_TIME, 8'h23, 8'h59, 8'h59);
    queue_cmd(MODE_TICK, 8'h00, 8'h00, 8'h00);
    // february 29: leap years accepted (2000 too), other years refused
    queue_cmd(MODE_SET_DATE, 8'h24, 8'h02, 8'h29);
    queue_cmd(MODE_SET_DATE, 8'h23, 8'h02, 8'h29);
    queue_cmd(MODE_SET_DATE, 8'h00, 8'h02, 8'h29);
    queue_cmd(MODE_SET_TIME, 8'h23, 8'h59, 8'h59);
    queue_cmd(MODE_TICK, 8'h00, 8'h00, 8'h00);
    // end of a 30-day month
    queue_cmd(MODE_SET_DATE, 8'h21, 8'h04, 8'h30);
    queue_cmd(MODE_SET_TIME, 8'h23, 8'h59, 8'h59);
    queue_cmd(MODE_TICK, 8'h00, 8'h00, 8'h00);
    // bad dates: day past month end, month 13, month 0, day 0, non-decimal nibbles
    queue_cmd(MODE_SET_DATE, 8'h10, 8'h04, 8'h31);
    queue_cmd(MODE_SET_DATE, 8'h10, 8'h13, 8'h01);
    queue_cmd(MODE_SET_DATE, 8'h10, 8'h00, 8'h01);
    queue_cmd(MODE_SET_DATE, 8'h10, 8'h01, 8'h00);
    queue_cmd(MODE_SET_DATE, 8'hff, 8'hff, 8'hff);
    // bad times: hour 24, minute 60, non-decimal hour, non-decimal second
    queue_cmd(MODE_SET_TIME, 8'h24, 8'h00, 8'h00);
    queue_cmd(MODE_SET_TIME, 8'h12, 8'h60, 8'h00);
    queue_cmd(MODE_SET_TIME, 8'h1a, 8'h00, 8'h00);
    queue_cmd(MODE_SET_TIME, 8'h00, 8'h00, 8'hff);
    // unused mode with all ones, then the lowest legal time
    queue_cmd(MODE_UNUSED, 8'hff, 8'hff, 8'hff);
    queue_cmd(MODE_SET_TIME, 8'h00, 8'h00, 8'h00);

    // random: mostly set-then-tick sequences around midnight, the rest singles and noise
    made = 0;
    while (made < RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 1) != 0) begin
          queue_good_date();
          made++;
        end
        queue_good_time(1'b1);
        n = $urandom_range(1, 24);
        queue_ticks(n);
        made += n + 1;
      end else if (pick < 65) begin
        if ($urandom_range(0, 1) != 0) queue_good_time(1'b0);
        else queue_good_date();
        made++;
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: begin
            // day one past the month end
            y  = $urandom_range(0, 99);
            mo = $urandom_range(1, 12);
            queue_cmd(MODE_SET_DATE, to_bcd(y), to_bcd(mo), to_bcd(month_days(mo, y) + 1));
          end
          1: begin
            queue_cmd(MODE_SET_TIME, to_bcd($urandom_range(20, 29)),
                      to_bcd($urandom_range(55, 65)), to_bcd($urandom_range(55, 65)));
          end
          default: begin
            queue_cmd(($urandom_range(0, 1) != 0) ? MODE_SET_TIME : MODE_SET_DATE,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
          end
        endcase
        made++;
      end else if (pick < 95) begin
        n = $urandom_range(1, 5);
        queue_ticks(n);
        made += n;
      end else begin
        // ignored by the dut, not counted
        queue_cmd(MODE_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end
    end
    total_cmds = pending_cmds.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (accepted_cmds == total_cmds);
    wait (predicted_readings.size() == 0);
    // stray beats after the last reading would show up here
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d command beats: %0d ticks, %0d set-time, %0d set-date, %0d unused",
             accepted_cmds, tick_cmds, set_time_cmds, set_date_cmds, unused_cmds);
    $display("%0d readings checked, %0d day rollovers, %0d refused set commands",
             readings_seen, rollovers, refusals);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d of %0d commands accepted", accepted_cmds, total_cmds);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### rtc_time_and_calendar_unit.f
rtl/core/rtc_pkg.sv
rtl/core/rtc_if.sv
rtl/core/rtc_time_and_calendar_unit.sv
tb/tb_rtc_time_and_calendar_unit.sv
